FILE: hdl/irtx_pkg.sv
// Shared types, constants and a helper function for the IR pulse-distance transmitter.
package irtx_pkg;

   // Timer and code geometry.
   localparam int TIMER_WIDTH  = 16;
   localparam int PREFIX_BITS  = 16;
   localparam int CODE_BITS    = 16;
   localparam int PRELOAD_BITS = 16;
   localparam int REG_BITS     = 16;
   localparam int COUNT_BITS   = 6;
   localparam logic [PRELOAD_BITS-1:0] TAIL_PRELOAD = 16'h0F00;
   localparam logic [COUNT_BITS-1:0] CODE_COUNT = COUNT_BITS'(CODE_BITS);
   localparam logic [COUNT_BITS-1:0] MAX_COUNT  = COUNT_BITS'(CODE_BITS + PREFIX_BITS);
   localparam logic [63:0] TIMER_TOP = (64'd1 << TIMER_WIDTH) - 64'd1;

   // Input function codes.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 3;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HEADER_FIRST  = 3'd0,
      CSR_HEADER_SECOND = 3'd1,
      CSR_ONE_FIRST     = 3'd2,
      CSR_ZERO_FIRST    = 3'd3,
      CSR_ONE_SECOND    = 3'd4,
      CSR_ZERO_SECOND   = 3'd5,
      CSR_PREFIX_CODE   = 3'd6
   } csr_index_type;

   // Transmit sequence phases.
   typedef enum logic [2:0] {
      PH_STOPPED = 3'd0,
      PH_ARMED   = 3'd1,
      PH_HDR_B   = 3'd2,
      PH_EDGE_A  = 3'd3,
      PH_EDGE_B  = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   // Configuration register set.
   typedef struct packed {
      logic [REG_BITS-1:0] header_first_len;
      logic [REG_BITS-1:0] header_second_len;
      logic [REG_BITS-1:0] one_first_len;
      logic [REG_BITS-1:0] zero_first_len;
      logic [REG_BITS-1:0] one_second_len;
      logic [REG_BITS-1:0] zero_second_len;
      logic [REG_BITS-1:0] prefix_code;
   } config_type;

   // One result item plus its valid flag.
   typedef struct packed {
      logic                    valid;
      logic                    line_level;
      logic [PRELOAD_BITS-1:0] timer_preload;
      logic                    finished;
   } result_type;

   // Timer preload for a phase of the given length: timer maximum minus length.
   function automatic logic [PRELOAD_BITS-1:0] preload_for(input logic [REG_BITS-1:0] len);
      logic [63:0] diff;
      diff = TIMER_TOP - 64'(len);
      return diff[PRELOAD_BITS-1:0];
   endfunction

endpackage

FILE: hdl/irtx_stream_if.sv
// Valid/ready channel interfaces for the transmitter's request and response streams.
interface irtx_req_if
   import irtx_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [CODE_BITS-1:0]  code_word;
   logic [COUNT_BITS-1:0] bit_count;

   modport source (output valid, output func, output code_word, output bit_count,
                   input ready);
   modport sink   (input valid, input func, input code_word, input bit_count,
                   output ready);
endinterface

interface irtx_rsp_if
   import irtx_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic                    line_level;
   logic [PRELOAD_BITS-1:0] timer_preload;
   logic                    finished;

   modport source (output valid, output line_level, output timer_preload,
                   output finished, input ready);
   modport sink   (input valid, input line_level, input timer_preload,
                   input finished, output ready);
endinterface

FILE: hdl/irtx_seq.sv
// Transmit sequencer: phase state machine and per-step line level and preload.
module irtx_seq
   import irtx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  func,
   input  logic [CODE_BITS-1:0]  code_word,
   input  logic [COUNT_BITS-1:0] bit_count,
   input  config_type            cfg,
   output result_type            result
);

   phase_type             phase_ff, phase_in;
   logic                  level_ff, level_in;
   logic [COUNT_BITS-1:0] bits_left_ff, bits_left_in;
   logic [CODE_BITS-1:0]  code_store_ff, code_store_in;
   logic                  current_bit_ff, current_bit_in;

   logic [COUNT_BITS-1:0] prefix_idx;
   logic [COUNT_BITS-1:0] code_idx;
   logic                  next_bit;
   logic                  header_first_on;

   assign header_first_on = (cfg.header_first_len != '0);

   // Pick the bit that the next edge pair carries, most significant first.
   assign prefix_idx = bits_left_ff - CODE_COUNT - COUNT_BITS'(1);
   assign code_idx   = bits_left_ff - COUNT_BITS'(1);
   always_comb begin
      if (bits_left_ff > CODE_COUNT) begin
         if (prefix_idx < COUNT_BITS'(REG_BITS)) begin
            next_bit = cfg.prefix_code[prefix_idx[3:0]];
         end else begin
            next_bit = 1'b0;
         end
      end else begin
         next_bit = code_store_ff[code_idx[3:0]];
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (func == FUNC_START) begin
            phase_in = PH_ARMED;
         end else begin
            unique case (phase_ff)
               PH_ARMED:   phase_in = header_first_on ? PH_HDR_B : PH_EDGE_A;
               PH_HDR_B:   phase_in = PH_EDGE_A;
               PH_EDGE_A:  phase_in = (bits_left_ff == '0) ? PH_DONE : PH_EDGE_B;
               PH_EDGE_B:  phase_in = PH_EDGE_A;
               PH_DONE:    phase_in = PH_STOPPED;
               default:    phase_in = phase_ff;
            endcase
         end
      end
   end

   // Datapath state and the result of this step.
   always_comb begin
      level_in       = level_ff;
      bits_left_in   = bits_left_ff;
      code_store_in  = code_store_ff;
      current_bit_in = current_bit_ff;
      result         = '0;
      if (accept) begin
         if (func == FUNC_START) begin
            code_store_in  = code_word;
            bits_left_in   = (bit_count > MAX_COUNT) ? MAX_COUNT : bit_count;
            level_in       = 1'b0;
            current_bit_in = 1'b0;
         end else begin
            unique case (phase_ff) inside
               PH_ARMED, PH_HDR_B: begin
                  level_in      = ~level_ff;
                  result.valid  = 1'b1;
                  result.line_level = ~level_ff;
                  if (phase_ff == PH_ARMED && header_first_on) begin
                     result.timer_preload = preload_for(cfg.header_first_len);
                  end else begin
                     result.timer_preload = preload_for(cfg.header_second_len);
                  end
               end
               PH_EDGE_A: begin
                  result.valid = 1'b1;
                  if (bits_left_ff == '0) begin
                     // Tail: line low with the fixed preload.
                     level_in             = 1'b0;
                     result.line_level    = 1'b0;
                     result.timer_preload = TAIL_PRELOAD;
                  end else begin
                     level_in             = ~level_ff;
                     current_bit_in       = next_bit;
                     result.line_level    = ~level_ff;
                     result.timer_preload = preload_for(next_bit ? cfg.one_first_len
                                                                 : cfg.zero_first_len);
                  end
               end
               PH_EDGE_B: begin
                  level_in             = ~level_ff;
                  bits_left_in         = bits_left_ff - COUNT_BITS'(1);
                  result.valid         = 1'b1;
                  result.line_level    = ~level_ff;
                  result.timer_preload = preload_for(current_bit_ff ? cfg.one_second_len
                                                                    : cfg.zero_second_len);
               end
               PH_DONE: begin
                  level_in        = 1'b0;
                  result.valid    = 1'b1;
                  result.finished = 1'b1;
               end
               default: begin
                  result = '0;
               end
            endcase
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_STOPPED;
         level_ff       <= 1'b0;
         bits_left_ff   <= '0;
         code_store_ff  <= '0;
         current_bit_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         level_ff       <= level_in;
         bits_left_ff   <= bits_left_in;
         code_store_ff  <= code_store_in;
         current_bit_ff <= current_bit_in;
      end
   end

endmodule

FILE: hdl/irtx_out_reg.sv
// Output register holding one result transaction until the receiver takes it.
module irtx_out_reg
   import irtx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       can_take,
   irtx_rsp_if.source rsp_chan
);

   logic                    valid_ff, valid_in;
   logic                    level_ff, level_in;
   logic [PRELOAD_BITS-1:0] preload_ff, preload_in;
   logic                    finished_ff, finished_in;

   // The register can load when it is empty or being drained this cycle.
   assign can_take = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in    = valid_ff;
      level_in    = level_ff;
      preload_in  = preload_ff;
      finished_in = finished_ff;
      if (can_take) begin
         valid_in    = result.valid;
         level_in    = result.line_level;
         preload_in  = result.timer_preload;
         finished_in = result.finished;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      preload_ff  <= preload_in;
      finished_ff <= finished_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.line_level    = level_ff;
   assign rsp_chan.timer_preload = preload_ff;
   assign rsp_chan.finished      = finished_ff;

endmodule

FILE: hdl/pulse_distance_ir_transmitter_top.sv
// Top level of the pulse-distance IR transmit sequencer with its register file.
//
// Usage: a start transaction on req_chan (func = 0) loads the code word and
// bit count and arms the sequencer; it gives no response. Each tick
// transaction (func = 1) advances the sequence one step and gives one
// response on rsp_chan: the new line level and the preload for the timer's
// next phase, or, on the last step, the finished flag. A tick while stopped
// gives no response.
// A response is registered and appears on rsp_chan in the cycle after its tick is
// accepted. Throughput: one transaction per cycle while rsp_chan is not stalled; the sequencer step is a
// single pass of logic between the state registers and the output register.
// Stall: when the receiver holds rsp_chan.ready low with a response waiting,
// req_chan.ready drops until the response is taken; nothing is lost.
// Reset: synchronous, active high; clears the registers to zero, stops the
// sequencer and empties the output register. Unknown register indexes are ignored.
// Registers are written through csr_write_enable, csr_index and csr_write_data;
// the user must write them only while the block is idle; the block does not enforce it.
module pulse_distance_ir_transmitter_top
   import irtx_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   irtx_req_if.sink                  req_chan,
   irtx_rsp_if.source                rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0]       csr_write_data
);

   config_type cfg_ff, cfg_in;
   result_type result;
   logic       can_take;
   logic       accept;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:  cfg_in.header_first_len  = csr_write_data;
            CSR_HEADER_SECOND: cfg_in.header_second_len = csr_write_data;
            CSR_ONE_FIRST:     cfg_in.one_first_len     = csr_write_data;
            CSR_ZERO_FIRST:    cfg_in.zero_first_len    = csr_write_data;
            CSR_ONE_SECOND:    cfg_in.one_second_len    = csr_write_data;
            CSR_ZERO_SECOND:   cfg_in.zero_second_len   = csr_write_data;
            CSR_PREFIX_CODE:   cfg_in.prefix_code       = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request handshake.
   assign req_chan.ready = can_take;
   assign accept         = req_chan.valid && can_take;

   irtx_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_chan.func),
      .code_word (req_chan.code_word),
      .bit_count (req_chan.bit_count),
      .cfg       (cfg_ff),
      .result    (result)
   );

   irtx_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .can_take (can_take),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the pulse-distance IR transmit sequencer.
module testbench
   import irtx_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REG_COUNT = 7;
   localparam int DIRECTED_ROWS = 26;
   localparam int RANDOM_ITEMS = 800;
   localparam logic [PRELOAD_BITS-1:0] TIMER_MAX = 16'hFFFF;

   // One response transaction: line level, timer preload and finished flag.
   typedef struct packed {
      logic                    line_level;
      logic [PRELOAD_BITS-1:0] timer_preload;
      logic                    finished;
   } line_step_type;

   // Directed table: a request transaction or a register write per row.
   typedef enum logic [1:0] {
      ROW_TRANSFER,
      ROW_REGISTER
   } row_kind_type;

   // How a request row is checked: by the predictor, as silent, or by typed values.
   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_SILENT,
      CHK_TYPED
   } row_check_type;

   typedef struct packed {
      row_kind_type            kind;
      logic                    func;
      logic [REG_BITS-1:0]     data;
      logic [COUNT_BITS-1:0]   count;
      csr_index_type           sel;
      row_check_type           check;
      logic                    lvl;
      logic [PRELOAD_BITS-1:0] pre;
      logic                    fin;
   } stim_row_type;

   localparam stim_row_type DIRECTED_STIMULUS [DIRECTED_ROWS] = '{
      // Reset settings: a tick while stopped, then an empty code word.
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_SILENT, 1'b0, 16'h0000, 1'b0},
      '{ROW_TRANSFER, FUNC_START, 16'hFFFF, 6'd0,  CSR_HEADER_FIRST,  CHK_SILENT, 1'b0, 16'h0000, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_TYPED,  1'b1, 16'hFFFF, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_TYPED,  1'b0, 16'h0F00, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_TYPED,  1'b0, 16'h0000, 1'b1},
      '{ROW_TRANSFER, FUNC_TICK,  16'hFFFF, 6'd63, CSR_HEADER_FIRST,  CHK_SILENT, 1'b0, 16'h0000, 1'b0},
      // Distinct timing for every register.
      '{ROW_REGISTER, FUNC_TICK,  16'h0064, 6'd0,  CSR_HEADER_FIRST,  CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      '{ROW_REGISTER, FUNC_TICK,  16'h00C8, 6'd0,  CSR_HEADER_SECOND, CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      '{ROW_REGISTER, FUNC_TICK,  16'h0001, 6'd0,  CSR_ONE_FIRST,     CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      '{ROW_REGISTER, FUNC_TICK,  16'hFFFF, 6'd0,  CSR_ZERO_FIRST,    CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      '{ROW_REGISTER, FUNC_TICK,  16'h0000, 6'd0,  CSR_ONE_SECOND,    CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      '{ROW_REGISTER, FUNC_TICK,  16'h8000, 6'd0,  CSR_ZERO_SECOND,   CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      '{ROW_REGISTER, FUNC_TICK,  16'h8001, 6'd0,  CSR_PREFIX_CODE,   CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      // Oversized count saturates; the first bits come from the prefix register.
      '{ROW_TRANSFER, FUNC_START, 16'h0000, 6'd63, CSR_HEADER_FIRST,  CHK_SILENT, 1'b0, 16'h0000, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_TYPED,  1'b1, 16'hFF9B, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_TYPED,  1'b0, 16'hFF37, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_TYPED,  1'b1, 16'hFFFE, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_TYPED,  1'b0, 16'hFFFF, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_TYPED,  1'b1, 16'h0000, 1'b0},
      // Restart in the middle of a transmission with a single bit.
      '{ROW_TRANSFER, FUNC_START, 16'h8001, 6'd1,  CSR_HEADER_FIRST,  CHK_SILENT, 1'b0, 16'h0000, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_MODEL,  1'b0, 16'h0000, 1'b0},
      '{ROW_TRANSFER, FUNC_TICK,  16'h0000, 6'd0,  CSR_HEADER_FIRST,  CHK_MODEL,  1'b0, 16'h0000, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   csr_index_type csr_index;
   logic [REG_BITS-1:0] csr_write_data;

   irtx_req_if req_chan ();
   irtx_rsp_if rsp_chan ();

   pulse_distance_ir_transmitter_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predicted sequencer state and register copies.
   phase_type             seq_phase;
   logic                  seq_level;
   logic [COUNT_BITS-1:0] seq_bits_left;
   logic [CODE_BITS-1:0]  seq_code;
   logic                  seq_bit;
   logic [REG_BITS-1:0]   reg_shadow [REG_COUNT];

   line_step_type line_steps_due [$];
   int unsigned   mismatches = 0;
   int unsigned   items_done = 0;
   bit            steady_run = 1'b0;

   always #5 clock = ~clock;

   // Advance the predicted sequencer by one request; returns 1 when a response follows.
   function automatic bit advance_sequencer(input logic fn, input logic [CODE_BITS-1:0] code,
         input logic [COUNT_BITS-1:0] count, output line_step_type step);
      logic [COUNT_BITS-1:0] prefix_pos;
      logic [COUNT_BITS-1:0] code_pos;
      logic [REG_BITS-1:0]   len;
      step = '0;
      if (fn == FUNC_START) begin
         seq_code = code;
         seq_bits_left = (count > MAX_COUNT) ? MAX_COUNT : count;
         seq_level = 1'b0;
         seq_bit = 1'b0;
         seq_phase = PH_ARMED;
         return 1'b0;
      end
      case (seq_phase) inside
         PH_ARMED, PH_HDR_B: begin
            // The first header is skipped when its length is zero.
            seq_level = ~seq_level;
            if (seq_phase == PH_ARMED && reg_shadow[CSR_HEADER_FIRST] != '0) begin
               seq_phase = PH_HDR_B;
               len = reg_shadow[CSR_HEADER_FIRST];
            end else begin
               seq_phase = PH_EDGE_A;
               len = reg_shadow[CSR_HEADER_SECOND];
            end
            step = '{seq_level, TIMER_MAX - len, 1'b0};
         end
         PH_EDGE_A: begin
            if (seq_bits_left == '0) begin
               // All bits sent: the line drops for the tail.
               seq_level = 1'b0;
               seq_phase = PH_DONE;
               step = '{1'b0, TAIL_PRELOAD, 1'b0};
            end else begin
               // Bits above the code word come from the prefix register.
               seq_level = ~seq_level;
               if (seq_bits_left > CODE_COUNT) begin
                  prefix_pos = seq_bits_left - CODE_COUNT - 1'b1;
                  seq_bit = (prefix_pos < REG_BITS) ?
                            reg_shadow[CSR_PREFIX_CODE][prefix_pos[3:0]] : 1'b0;
               end else begin
                  code_pos = seq_bits_left - 1'b1;
                  seq_bit = seq_code[code_pos[3:0]];
               end
               len = seq_bit ? reg_shadow[CSR_ONE_FIRST] : reg_shadow[CSR_ZERO_FIRST];
               seq_phase = PH_EDGE_B;
               step = '{seq_level, TIMER_MAX - len, 1'b0};
            end
         end
         PH_EDGE_B: begin
            seq_level = ~seq_level;
            seq_bits_left = seq_bits_left - 1'b1;
            len = seq_bit ? reg_shadow[CSR_ONE_SECOND] : reg_shadow[CSR_ZERO_SECOND];
            seq_phase = PH_EDGE_A;
            step = '{seq_level, TIMER_MAX - len, 1'b0};
         end
         PH_DONE: begin
            seq_level = 1'b0;
            seq_phase = PH_STOPPED;
            step = '{1'b0, '0, 1'b1};
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Send one request transaction, with an occasional gap before it.
   task automatic transfer(input logic fn, input logic [CODE_BITS-1:0] code,
         input logic [COUNT_BITS-1:0] count, input bit push_model);
      line_step_type step;
      bit            produced;
      if (!steady_run && $urandom_range(0, 99) < 12) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= fn;
      req_chan.code_word <= code;
      req_chan.bit_count <= count;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      produced = advance_sequencer(fn, code, count, step);
      if (produced && push_model) line_steps_due.push_back(step);
      if (fn == FUNC_START || produced) items_done++;
   endtask

   // Hold requests until every response has arrived and the block has settled.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (line_steps_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input logic [REG_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= sel;
      csr_write_data <= value;
      @(posedge clock);
      reg_shadow[sel] = value;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Load a timing set: all ones first, then all zeros, then mixed random sets.
   task automatic load_timing_set(input int unsigned set_no);
      logic [REG_BITS-1:0] value;
      drain();
      for (int i = 0; i < REG_COUNT; i++) begin
         if (set_no == 0) begin
            value = '1;
         end else if (set_no == 1) begin
            value = '0;
         end else begin
            case ($urandom_range(0, 3))
               0: value = '0;
               1: value = '1;
               default: value = REG_BITS'($urandom);
            endcase
         end
         write_reg(csr_index_type'(i), value);
      end
   endtask

   // Response side: random back-pressure and in-order comparison.
   always @(posedge clock) begin
      rsp_chan.ready <= steady_run || ($urandom_range(0, 99) >= 12);
   end

   always @(posedge clock) begin
      line_step_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (line_steps_due.size() == 0) begin
            $error("unexpected transaction: line_level %0d timer_preload %h finished %0d",
                   rsp_chan.line_level, rsp_chan.timer_preload, rsp_chan.finished);
            mismatches++;
         end else begin
            want = line_steps_due.pop_front();
            if (rsp_chan.line_level !== want.line_level) begin
               $error("line_level: expected %0d, actual %0d",
                      want.line_level, rsp_chan.line_level);
               mismatches++;
            end
            if (rsp_chan.timer_preload !== want.timer_preload) begin
               $error("timer_preload: expected %h, actual %h",
                      want.timer_preload, rsp_chan.timer_preload);
               mismatches++;
            end
            if (rsp_chan.finished !== want.finished) begin
               $error("finished: expected %0d, actual %0d", want.finished, rsp_chan.finished);
               mismatches++;
            end
         end
      end
   end

   // Stimulus: reset, directed table, then random transmissions.
   initial begin
      stim_row_type          row;
      logic [CODE_BITS-1:0]  code;
      logic [COUNT_BITS-1:0] count;
      int                    ticks;
      int unsigned           set_no;
      int unsigned           transmissions;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_START;
      req_chan.code_word = '0;
      req_chan.bit_count = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_HEADER_FIRST;
      csr_write_data = '0;
      seq_phase = PH_STOPPED;
      seq_level = 1'b0;
      seq_bits_left = '0;
      seq_code = '0;
      seq_bit = 1'b0;
      foreach (reg_shadow[i]) reg_shadow[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed rows.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED_STIMULUS[i];
         if (row.kind == ROW_REGISTER) begin
            drain();
            write_reg(row.sel, row.data);
         end else begin
            transfer(row.func, row.data, row.count, row.check == CHK_MODEL);
            if (row.check == CHK_TYPED) begin
               line_steps_due.push_back(line_step_type'{row.lvl, row.pre, row.fin});
            end
         end
      end

      // Random transmissions, mostly complete, some cut short, some noise.
      items_done = 0;
      set_no = 0;
      transmissions = 0;
      while (items_done < RANDOM_ITEMS) begin
         if (transmissions % 6 == 0) begin
            load_timing_set(set_no);
            set_no++;
         end
         steady_run = (items_done >= 300 && items_done < 450);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               transfer(1'($urandom_range(0, 1)), CODE_BITS'($urandom),
                        COUNT_BITS'($urandom), 1'b1);
            end
         end else begin
            code = CODE_BITS'($urandom);
            case ($urandom_range(0, 9)) inside
               0: count = COUNT_BITS'($urandom_range(33, 63));
               1, 2: count = COUNT_BITS'($urandom_range(17, 32));
               default: count = COUNT_BITS'($urandom_range(0, 16));
            endcase
            transfer(FUNC_START, code, count, 1'b1);
            // Ticks for the headers, the edges of each bit, the tail and the finish.
            ticks = 2 * ((count > MAX_COUNT) ? int'(MAX_COUNT) : int'(count)) + 4;
            if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, ticks - 1);
            repeat (ticks) transfer(FUNC_TICK, CODE_BITS'($urandom), COUNT_BITS'($urandom), 1'b1);
         end
         transmissions++;
      end
      steady_run = 1'b0;

      drain();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
